// ===== design/calendar_seconds_clock_defines.svh =====
// assertion macros for the calendar seconds clock
// used by the top level only, no other dependencies
`ifndef CALENDAR_SECONDS_CLOCK_DEFINES_SVH
`define CALENDAR_SECONDS_CLOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csc assertion failed");
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/csc_pkg.sv =====
// shared types, constants and the month length table for the calendar clock
// no dependencies
package csc_pkg;

    localparam int CSC_QUEUE_DEPTH = 4;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_LAST  = 4'd12;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] HOUR_LAST   = 5'd23;
    localparam logic [5:0] MINUTE_LAST = 6'd59;
    localparam logic [5:0] SECOND_LAST = 6'd59;

    typedef struct packed {
        logic       mode;
        logic [3:0] set_month;
        logic [4:0] set_day;
        logic [4:0] set_hour;
        logic [5:0] set_minute;
        logic [5:0] set_second;
    } csc_in_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       load_error;
    } csc_out_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_REJECT = 2'd2
    } csc_op_t;

    // classified command as it sits in the queue
    typedef struct packed {
        csc_op_t    op;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } csc_cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } csc_q_status_t;

    // zero for codes that are not a month
    function automatic logic [4:0] days_in_month(input logic [3:0] month);
        logic [4:0] days;
        case (month)
            4'd1:    days = 5'd31;
            4'd2:    days = 5'd28;
            4'd3:    days = 5'd31;
            4'd4:    days = 5'd30;
            4'd5:    days = 5'd31;
            4'd6:    days = 5'd30;
            4'd7:    days = 5'd31;
            4'd8:    days = 5'd31;
            4'd9:    days = 5'd30;
            4'd10:   days = 5'd31;
            4'd11:   days = 5'd30;
            4'd12:   days = 5'd31;
            default: days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== design/csc_front.sv =====
// front end: takes input beats and classifies them as tick, load or rejected load
// depends on csc_pkg
module csc_front
    import csc_pkg::*;
(
    input  logic          s_valid,
    output logic          s_ready,
    input  csc_in_t       s_data,
    input  csc_q_status_t q_status,
    output logic          push,
    output csc_cmd_t      push_cmd
);

    logic load_ok;

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    always_comb begin
        load_ok = (s_data.set_month >= MONTH_FIRST) && (s_data.set_month <= MONTH_LAST)
               && (s_data.set_day >= DAY_FIRST)
               && (s_data.set_day <= days_in_month(s_data.set_month))
               && (s_data.set_hour <= HOUR_LAST)
               && (s_data.set_minute <= MINUTE_LAST)
               && (s_data.set_second <= SECOND_LAST);

        push_cmd.month  = s_data.set_month;
        push_cmd.day    = s_data.set_day;
        push_cmd.hour   = s_data.set_hour;
        push_cmd.minute = s_data.set_minute;
        push_cmd.second = s_data.set_second;
        if (!s_data.mode) begin
            push_cmd.op = OP_TICK;
        end else if (load_ok) begin
            push_cmd.op = OP_LOAD;
        end else begin
            push_cmd.op = OP_REJECT;
        end
    end

endmodule

// ===== design/csc_queue.sv =====
// small command queue between front and back, flop based
// depends on csc_pkg
module csc_queue
    import csc_pkg::*;
#(
    parameter int DEPTH = CSC_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  csc_cmd_t      push_cmd,
    input  logic          pop,
    output csc_cmd_t      pop_cmd,
    output csc_q_status_t status
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

    csc_cmd_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign status.full      = (count_reg == COUNT_FULL);
    assign status.not_empty = (count_reg != '0);
    assign pop_cmd          = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/csc_back.sv =====
// back end: holds the time of year as calendar counters, applies commands,
// and registers each result beat; depends on csc_pkg
module csc_back
    import csc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  csc_q_status_t q_status,
    input  csc_cmd_t      pop_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output csc_out_t      m_data
);

    // the seconds count is kept in mixed radix, so no division is needed
    logic [3:0] month_reg,  month_next;
    logic [4:0] day_reg,    day_next;
    logic [4:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic       m_valid_reg, m_valid_next;
    csc_out_t   m_data_reg, m_data_next;

    assign pop     = q_status.not_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        if (pop) begin
            case (pop_cmd.op)
                OP_TICK: begin
                    if (second_reg != SECOND_LAST) begin
                        second_next = second_reg + 1'b1;
                    end else begin
                        second_next = '0;
                        if (minute_reg != MINUTE_LAST) begin
                            minute_next = minute_reg + 1'b1;
                        end else begin
                            minute_next = '0;
                            if (hour_reg != HOUR_LAST) begin
                                hour_next = hour_reg + 1'b1;
                            end else begin
                                hour_next = '0;
                                if (day_reg != days_in_month(month_reg)) begin
                                    day_next = day_reg + 1'b1;
                                end else begin
                                    day_next = DAY_FIRST;
                                    // year wrap after december 31
                                    month_next = (month_reg == MONTH_LAST) ? MONTH_FIRST
                                                                            : month_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_LOAD: begin
                    month_next  = pop_cmd.month;
                    day_next    = pop_cmd.day;
                    hour_next   = pop_cmd.hour;
                    minute_next = pop_cmd.minute;
                    second_next = pop_cmd.second;
                end
                default: begin
                end
            endcase
        end

        m_data_next            = m_data_reg;
        m_valid_next           = m_valid_reg;
        if (pop) begin
            m_valid_next           = 1'b1;
            m_data_next.month      = month_next;
            m_data_next.day        = day_next;
            m_data_next.hour       = hour_next;
            m_data_next.minute     = minute_next;
            m_data_next.second     = second_next;
            m_data_next.load_error = (pop_cmd.op == OP_REJECT);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            month_reg   <= MONTH_FIRST;
            day_reg     <= DAY_FIRST;
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            month_reg   <= month_next;
            day_reg     <= day_next;
            hour_reg    <= hour_next;
            minute_reg  <= minute_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

// ===== design/calendar_seconds_clock.sv =====
// top level of the calendar seconds clock: front, command queue, back
// depends on csc_pkg, csc_front, csc_queue, csc_back and the defines header
//
//   channel  dir  payload     beat
//   s_       in   csc_in_t    tick or load of month, day, hour, minute, second
//   m_       out  csc_out_t   time after the update, plus load_error
//
// one beat per cycle sustained while m_ready stays high; an input beat is written into the queue
// and then goes through the calendar update into the output register
// reset gives january 1, 00:00:00 and empties queue and output, no clearing pass
// the queue holds QUEUE_DEPTH beats while m_ready is low; s_ready drops when it is full
`include "calendar_seconds_clock_defines.svh"
module calendar_seconds_clock
    import csc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CSC_QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  csc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output csc_out_t m_data
);

    csc_q_status_t q_status;
    csc_cmd_t      push_cmd;
    csc_cmd_t      pop_cmd;
    logic          push;
    logic          pop;
    logic          out_in_range;

    csc_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    csc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign out_in_range = (m_data.month >= MONTH_FIRST) && (m_data.month <= MONTH_LAST)
                       && (m_data.day >= DAY_FIRST)
                       && (m_data.day <= days_in_month(m_data.month))
                       && (m_data.hour <= HOUR_LAST)
                       && (m_data.minute <= MINUTE_LAST)
                       && (m_data.second <= SECOND_LAST);

    // a presented result is always a real calendar time
    `CSC_ASSERT_IMPL(a_out_range, aclk, aresetn, m_valid, out_in_range)
    // queued work with room at the output shows up next cycle
    `CSC_ASSERT_NEXT(a_pop_delivers, aclk, aresetn, q_status.not_empty && (!m_valid || m_ready), m_valid)
    // nothing queued and the beat taken leaves the output empty
    `CSC_ASSERT_NEXT(a_drain_empty, aclk, aresetn, !q_status.not_empty && m_ready, !m_valid)

endmodule

// ===== dv/calendar_seconds_clock_tb.sv =====
// self-checking testbench for calendar_seconds_clock: ticks and date loads in, decoded time out
// keeps its own seconds count to predict every result; depends on csc_pkg and the rtl only
module calendar_seconds_clock_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csc_pkg::*;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned SECS_PER_HOUR = 60 * 60;
    localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
    localparam int unsigned SECS_PER_YEAR = 365 * SECS_PER_DAY;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam int unsigned ITEM_TARGET = 1150;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned REPORT_MAX  = 10;

    class calendar_board;
        int unsigned month_days[12];
        int unsigned secs_into_year;
        csc_out_t    pending_times[$];
        int unsigned results_seen;
        int unsigned mismatch_count;

        function new();
            month_days     = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            secs_into_year = 0;
            results_seen   = 0;
            mismatch_count = 0;
        endfunction

        function string show(csc_out_t t);
            return $sformatf("%0d/%0d %0d:%0d:%0d err %0b",
                             t.month, t.day, t.hour, t.minute, t.second, t.load_error);
        endfunction

        // called for each accepted input beat
        function void advance_clock(csc_in_t beat);
            csc_out_t    want;
            int unsigned mon;
            int unsigned dom;
            int unsigned day_num;
            int unsigned mon_idx;
            bit          fields_ok;
            want = '0;
            if (beat.mode == MODE_TICK) begin
                if (secs_into_year + 1 >= SECS_PER_YEAR) begin
                    secs_into_year = 0;
                end else begin
                    secs_into_year = secs_into_year + 1;
                end
            end else begin
                mon = 32'(beat.set_month);
                dom = 32'(beat.set_day);
                fields_ok = (beat.set_month >= MONTH_FIRST) && (beat.set_month <= MONTH_LAST);
                if (fields_ok) begin
                    fields_ok = (dom >= 1) && (dom <= month_days[mon - 1]);
                end
                fields_ok = fields_ok && (beat.set_hour <= HOUR_LAST) &&
                            (beat.set_minute <= MINUTE_LAST) && (beat.set_second <= SECOND_LAST);
                if (fields_ok) begin
                    day_num = dom - 1;
                    for (int m = 1; m < mon; m++) begin
                        day_num += month_days[m - 1];
                    end
                    secs_into_year = day_num * SECS_PER_DAY
                                   + 32'(beat.set_hour) * SECS_PER_HOUR
                                   + 32'(beat.set_minute) * SECS_PER_MIN
                                   + 32'(beat.set_second);
                end else begin
                    want.load_error = 1'b1;
                end
            end
            day_num = secs_into_year / SECS_PER_DAY;
            mon_idx = 0;
            while (mon_idx < 11 && day_num >= month_days[mon_idx]) begin
                day_num -= month_days[mon_idx];
                mon_idx++;
            end
            want.month  = 4'(mon_idx + 1);
            want.day    = 5'(day_num + 1);
            want.hour   = 5'((secs_into_year / SECS_PER_HOUR) % 24);
            want.minute = 6'((secs_into_year / SECS_PER_MIN) % 60);
            want.second = 6'(secs_into_year % 60);
            pending_times.push_back(want);
        endfunction

        function void compare_time(csc_out_t got);
            csc_out_t want;
            results_seen++;
            if (pending_times.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("%0t: result %0d with no beat waiting: got %s",
                             $time, results_seen, show(got));
                end
                return;
            end
            want = pending_times.pop_front();
            if (got.month !== want.month || got.day !== want.day ||
                got.hour !== want.hour || got.minute !== want.minute ||
                got.second !== want.second || got.load_error !== want.load_error) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("%0t: result %0d differs: expected %s, got %s",
                             $time, results_seen, show(want), show(got));
                end
            end
        endfunction
    endclass

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    csc_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    csc_out_t m_data;

    calendar_board board = new();
    int unsigned   beats_sent = 0;

    calendar_seconds_clock u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic csc_in_t noise_beat();
        logic [31:0] r;
        csc_in_t     b;
        r = $urandom;
        b = r[$bits(csc_in_t)-1:0];
        return b;
    endfunction

    // set fields carry junk on a tick, the block must ignore them
    function automatic csc_in_t tick_beat();
        csc_in_t b;
        b = noise_beat();
        b.mode = MODE_TICK;
        return b;
    endfunction

    function automatic csc_in_t load_beat(input int unsigned mon, input int unsigned dom,
                                          input int unsigned hr, input int unsigned mi,
                                          input int unsigned se);
        csc_in_t b;
        b.mode       = MODE_LOAD;
        b.set_month  = 4'(mon);
        b.set_day    = 5'(dom);
        b.set_hour   = 5'(hr);
        b.set_minute = 6'(mi);
        b.set_second = 6'(se);
        return b;
    endfunction

    // at_month_end puts the load in the last seconds of a month, so ticks roll it over
    function automatic csc_in_t pick_load(input bit at_month_end);
        int unsigned mon;
        int unsigned len;
        mon = $urandom_range(12, 1);
        len = board.month_days[mon - 1];
        if (at_month_end) begin
            return load_beat(mon, len, 23, 59, $urandom_range(59, 50));
        end
        return load_beat(mon, $urandom_range(len, 1), $urandom_range(23, 0),
                         $urandom_range(59, 0), $urandom_range(59, 0));
    endfunction

    // push exactly one field out of range
    function automatic csc_in_t spoil_load(input csc_in_t b);
        int unsigned len;
        len = board.month_days[32'(b.set_month) - 1];
        case ($urandom_range(4, 0))
            0: b.set_month = $urandom_range(1, 0) ? 4'd0 : 4'($urandom_range(15, 13));
            1: b.set_day = (len < 31 && $urandom_range(1, 0)) ?
                           5'($urandom_range(31, len + 1)) : 5'd0;
            2: b.set_hour = 5'($urandom_range(31, 24));
            3: b.set_minute = 6'($urandom_range(63, 60));
            default: b.set_second = 6'($urandom_range(63, 60));
        endcase
        return b;
    endfunction

    task automatic offer_beat(input csc_in_t beat);
        bit quiet;
        quiet = (beats_sent >= 300 && beats_sent < 480);
        while (!quiet && $urandom_range(99, 0) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        board.advance_clock(beat);
        beats_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending_times.size() != 0);
    endtask

    initial begin : stimulus
        csc_in_t     beat;
        int unsigned kind;
        bit          paused;
        paused = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        beat = '1;
        beat.mode = MODE_TICK;
        offer_beat(beat);
        beat = '0;
        offer_beat(beat);
        offer_beat(load_beat(1, 1, 0, 0, 0));
        offer_beat(load_beat(12, 31, 23, 59, 59));
        offer_beat(tick_beat());                        // year wrap
        offer_beat(load_beat(1, 31, 23, 59, 59));
        offer_beat(tick_beat());
        offer_beat(load_beat(2, 28, 23, 59, 59));
        offer_beat(tick_beat());
        offer_beat(load_beat(11, 30, 23, 59, 59));
        offer_beat(tick_beat());
        // rejected loads, the time must hold
        offer_beat(load_beat(0, 10, 5, 5, 5));
        offer_beat(load_beat(13, 10, 5, 5, 5));
        offer_beat(load_beat(15, 10, 5, 5, 5));
        offer_beat(load_beat(3, 0, 5, 5, 5));
        offer_beat(load_beat(2, 29, 5, 5, 5));
        offer_beat(load_beat(4, 31, 5, 5, 5));
        offer_beat(load_beat(6, 31, 5, 5, 5));
        offer_beat(load_beat(7, 4, 24, 5, 5));
        offer_beat(load_beat(7, 4, 31, 5, 5));
        offer_beat(load_beat(7, 4, 5, 60, 5));
        offer_beat(load_beat(7, 4, 5, 63, 5));
        offer_beat(load_beat(7, 4, 5, 5, 60));
        offer_beat(load_beat(7, 4, 5, 5, 63));
        offer_beat(load_beat(15, 31, 31, 63, 63));
        wait_for_drain();

        while (beats_sent < ITEM_TARGET) begin
            if (!paused && beats_sent >= 700) begin
                paused = 1'b1;
                wait_for_drain();
            end
            kind = $urandom_range(99, 0);
            if (kind < 40) begin
                repeat ($urandom_range(8, 1)) offer_beat(tick_beat());
            end else if (kind < 70) begin
                offer_beat(pick_load(1'b0));
                repeat ($urandom_range(5, 0)) offer_beat(tick_beat());
            end else if (kind < 85) begin
                offer_beat(pick_load(1'b1));
                repeat ($urandom_range(10, 1)) offer_beat(tick_beat());
            end else if (kind < 95) begin
                offer_beat(spoil_load(pick_load(1'b0)));
                repeat ($urandom_range(2, 0)) offer_beat(tick_beat());
            end else begin
                offer_beat(noise_beat());
            end
        end

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending_times.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            // one long hold-off so the queue fills and s_ready drops
            if (!hold_done && board.results_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = 80;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (board.results_seen >= 600 && board.results_seen < 780) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= 37);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.compare_time(m_data);
        end
    end

    initial begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                dead_cycles = 0;
            end else begin
                dead_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

endmodule
